FILE: rtl/core/pa_pkg.sv
// Shared types and codes for the primitive assembly block.
`timescale 1ns / 1ps

package pa_pkg;

    localparam int ID_W = 16;

    // Item function codes as they arrive on the input.
    localparam logic [1:0] FUNC_BEGIN  = 2'd0;
    localparam logic [1:0] FUNC_VERTEX = 2'd1;
    localparam logic [1:0] FUNC_END    = 2'd2;

    // Primitive modes carried by a begin word.
    localparam logic [2:0] MODE_POINTS    = 3'd0;
    localparam logic [2:0] MODE_LINES     = 3'd1;
    localparam logic [2:0] MODE_LOOP      = 3'd2;
    localparam logic [2:0] MODE_STRIP     = 3'd3;
    localparam logic [2:0] MODE_TRIS      = 3'd4;
    localparam logic [2:0] MODE_FAN       = 3'd5;
    localparam logic [2:0] MODE_TRI_STRIP = 3'd6;
    localparam logic [2:0] MODE_INVALID   = 3'd7;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_TRI   = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    // Classified command handed from front to back.
    typedef enum logic [1:0] {
        OP_BEGIN     = 2'd0,
        OP_BEGIN_BAD = 2'd1,
        OP_VERTEX    = 2'd2,
        OP_END       = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [2:0]       mode;
        logic [ID_W-1:0]  id;
    } t_cmd;

endpackage

FILE: rtl/core/pa_front.sv
// Front end: classifies incoming words into assembly commands.
`timescale 1ns / 1ps

module pa_front import pa_pkg::*; (
    input  logic [1:0]      i_func,
    input  logic [2:0]      i_mode,
    input  logic [ID_W-1:0] i_vertex_id,
    output logic            o_keep,
    output t_cmd            o_cmd
);

    always_comb begin
        o_keep      = 1'b1;
        o_cmd.mode  = i_mode;
        o_cmd.id    = i_vertex_id;
        o_cmd.op    = OP_VERTEX;
        case (i_func)
            FUNC_BEGIN: begin
                // an invalid mode is an error whatever the batch state
                o_cmd.op = (i_mode == MODE_INVALID) ? OP_BEGIN_BAD : OP_BEGIN;
            end
            FUNC_VERTEX: o_cmd.op = OP_VERTEX;
            FUNC_END:    o_cmd.op = OP_END;
            default: begin
                // unused function code: drop the word
                o_keep = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/pa_fifo.sv
// Short command queue between front and back.
`timescale 1ns / 1ps

module pa_fifo import pa_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_cmd o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/pa_back.sv
// Back end: batch state, vertex slots and the result register.
`timescale 1ns / 1ps

module pa_back import pa_pkg::*; #(
    parameter int ID_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_cmd_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [1:0]      o_prim_kind,
    output logic [ID_W-1:0] o_first_id,
    output logic [ID_W-1:0] o_second_id,
    output logic [ID_W-1:0] o_third_id
);

    localparam int SW = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_ONE  = 2'd1;
    localparam logic [1:0] PHASE_EVEN = 2'd2;
    localparam logic [1:0] PHASE_ODD  = 2'd3;

    logic            r_active, n_active;
    logic [2:0]      r_mode, n_mode;
    logic [1:0]      r_phase, n_phase;
    logic [1:0]      r_ptr, n_ptr;
    logic [SW-1:0]   r_slots [3];
    logic [SW-1:0]   n_slots [3];
    logic [SW-1:0]   w [3];
    logic [SW-1:0]   vid;

    logic            r_out_valid;
    t_kind           r_kind, n_kind;
    logic [ID_W-1:0] r_a, r_b, r_c, n_a, n_b, n_c;
    logic            n_res;

    logic            fire;
    logic [1:0]      p, p1, prev, prev2, last, last_idx;

    assign o_cmd_take  = i_cmd_valid && (!r_out_valid || i_pop);
    assign fire        = o_cmd_take;
    assign o_empty     = !r_out_valid;
    assign o_prim_kind = r_kind;
    assign o_first_id  = r_a;
    assign o_second_id = r_b;
    assign o_third_id  = r_c;

    assign vid      = i_cmd.id[SW-1:0];
    assign p        = (r_ptr == 2'd3) ? 2'd0 : r_ptr;
    assign p1       = p + 2'd1;
    assign prev     = (p == 2'd0) ? 2'd2 : p - 2'd1;
    assign prev2    = (p == 2'd2) ? 2'd0 : p + 2'd1;
    assign last     = 2'd3 - r_ptr;
    assign last_idx = (last == 2'd3) ? 2'd0 : last;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w[i] = (2'(i) == p) ? vid : r_slots[i];
        end
    end

    always_comb begin
        n_active = r_active;
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_ptr    = r_ptr;
        n_slots  = r_slots;
        n_res    = 1'b0;
        n_kind   = KIND_ERR;
        n_a      = '0;
        n_b      = '0;
        n_c      = '0;
        case (i_cmd.op)
            OP_BEGIN: begin
                if (r_active) begin
                    n_res = 1'b1;
                end else begin
                    n_active = 1'b1;
                    n_mode   = i_cmd.mode;
                    n_phase  = PHASE_IDLE;
                    n_ptr    = 2'd0;
                end
            end
            OP_BEGIN_BAD: n_res = 1'b1;
            OP_END: begin
                if (!r_active) begin
                    n_res = 1'b1;
                end else begin
                    // close the loop back to the first vertex
                    if (r_mode == MODE_LOOP && r_phase == PHASE_EVEN) begin
                        n_res  = 1'b1;
                        n_kind = KIND_LINE;
                        n_a    = ID_W'(r_slots[last_idx]);
                        n_b    = ID_W'(r_slots[0]);
                    end
                    n_active = 1'b0;
                end
            end
            OP_VERTEX: begin
                if (r_active) begin
                    if (r_mode != MODE_POINTS) begin
                        n_slots[p] = vid;
                    end
                    case (r_mode)
                        MODE_POINTS: begin
                            n_slots[0] = vid;
                            n_res      = 1'b1;
                            n_kind     = KIND_POINT;
                            n_a        = ID_W'(vid);
                        end
                        MODE_LINES: begin
                            n_ptr = p1;
                            if (p1 >= 2'd2) begin
                                n_res  = 1'b1;
                                n_kind = KIND_LINE;
                                n_a    = ID_W'(w[0]);
                                n_b    = ID_W'(w[1]);
                                n_ptr  = 2'd0;
                            end
                        end
                        MODE_LOOP: begin
                            if (r_phase == PHASE_EVEN) begin
                                n_res  = 1'b1;
                                n_kind = KIND_LINE;
                                n_a    = ID_W'(p1[0] ? w[1] : w[2]);
                                n_b    = ID_W'(p1[0] ? w[2] : w[1]);
                            end else if (r_phase == PHASE_ONE) begin
                                n_res   = 1'b1;
                                n_kind  = KIND_LINE;
                                n_a     = ID_W'(w[0]);
                                n_b     = ID_W'(w[1]);
                                n_phase = PHASE_EVEN;
                            end else begin
                                n_phase = PHASE_ONE;
                            end
                            // slot 0 keeps the first vertex for the closing line
                            n_ptr = (p1 == 2'd3) ? 2'd1 : p1;
                        end
                        MODE_STRIP: begin
                            if (r_phase != PHASE_IDLE) begin
                                n_res  = 1'b1;
                                n_kind = KIND_LINE;
                                n_a    = ID_W'(p1[0] ? w[1] : w[0]);
                                n_b    = ID_W'(p1[0] ? w[0] : w[1]);
                            end else begin
                                n_phase = PHASE_ONE;
                            end
                            n_ptr = (p1 >= 2'd2) ? 2'd0 : p1;
                        end
                        MODE_TRIS: begin
                            n_ptr = p1;
                            if (p1 == 2'd3) begin
                                n_res  = 1'b1;
                                n_kind = KIND_TRI;
                                n_a    = ID_W'(w[0]);
                                n_b    = ID_W'(w[1]);
                                n_c    = ID_W'(w[2]);
                                n_ptr  = 2'd0;
                            end
                        end
                        MODE_FAN, MODE_TRI_STRIP: begin
                            // alternate order between phases to keep the winding
                            if (r_phase == PHASE_ODD) begin
                                n_res   = 1'b1;
                                n_kind  = KIND_TRI;
                                n_a     = ID_W'(r_slots[prev]);
                                n_b     = ID_W'(r_slots[prev2]);
                                n_c     = ID_W'(vid);
                                n_phase = PHASE_EVEN;
                            end else if (r_phase == PHASE_EVEN) begin
                                n_res   = 1'b1;
                                n_kind  = KIND_TRI;
                                n_a     = ID_W'(r_slots[prev2]);
                                n_b     = ID_W'(r_slots[prev]);
                                n_c     = ID_W'(vid);
                                n_phase = PHASE_ODD;
                            end else begin
                                n_phase = r_phase + 2'd1;
                            end
                            if (p1 == 2'd3) begin
                                n_ptr = (r_mode == MODE_FAN) ? 2'd1 : 2'd0;
                            end else begin
                                n_ptr = p1;
                            end
                        end
                        default: n_res = 1'b0;
                    endcase
                end
            end
            default: n_res = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_slots <= n_slots;
        end
        if (fire && n_res) begin
            r_kind <= n_kind;
            r_a    <= n_a;
            r_b    <= n_b;
            r_c    <= n_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_mode      <= MODE_POINTS;
            r_phase     <= PHASE_IDLE;
            r_ptr       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_active <= n_active;
                r_mode   <= n_mode;
                r_phase  <= n_phase;
                r_ptr    <= n_ptr;
            end
            // hold the result until popped, refill in the same cycle
            if (fire && n_res) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/primitive_assembly_top.sv
// Top level of the primitive assembly block.
//
//  channel  | handshake         | word
//  ---------+-------------------+------------------------------------------
//  input    | i_push / o_full   | i_func, i_mode, i_vertex_id
//  result   | o_empty / i_pop   | o_prim_kind, o_first_id, o_second_id,
//           |                   | o_third_id
//
// One word is taken per cycle while o_full is low. A word is written into the
// command queue; the back end takes it from the queue head and registers any
// result in the result register, from which it can be popped. The back end retires
// one command per cycle while the result register is free or being popped.
// Reset is synchronous and active low; it closes any batch and empties the
// queue and result register. A stalled result stops the back end, and the
// queue raises o_full once QUEUE_DEPTH commands wait.
`timescale 1ns / 1ps

module primitive_assembly_top import pa_pkg::*; #(
    parameter int ID_BITS     = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [1:0]      i_func,
    input  logic [2:0]      i_mode,
    input  logic [ID_W-1:0] i_vertex_id,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [1:0]      o_prim_kind,
    output logic [ID_W-1:0] o_first_id,
    output logic [ID_W-1:0] o_second_id,
    output logic [ID_W-1:0] o_third_id
);

    t_cmd  front_cmd, queue_cmd;
    logic  front_keep;
    logic  queue_valid, cmd_take;

    pa_front u_front (
        .i_func      (i_func),
        .i_mode      (i_mode),
        .i_vertex_id (i_vertex_id),
        .o_keep      (front_keep),
        .o_cmd       (front_cmd)
    );

    pa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push && front_keep),
        .i_wdata (front_cmd),
        .o_full  (o_full),
        .i_rd    (cmd_take),
        .o_valid (queue_valid),
        .o_rdata (queue_cmd)
    );

    pa_back #(
        .ID_BITS (ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_prim_kind (o_prim_kind),
        .o_first_id  (o_first_id),
        .o_second_id (o_second_id),
        .o_third_id  (o_third_id)
    );

endmodule

FILE: dv/primitive_assembly_top_tb.sv
// Self-checking testbench for the primitive assembly block: directed and random streams.
`timescale 1ns / 1ps

module primitive_assembly_top_tb;
    import pa_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         RANDOM_WORDS = 1950;

    typedef struct packed {
        t_kind           kind;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
        logic [ID_W-1:0] third_id;
    } t_prim;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_push      = 1'b0;
    logic            o_full;
    logic [1:0]      i_func      = '0;
    logic [2:0]      i_mode      = '0;
    logic [ID_W-1:0] i_vertex_id = '0;
    logic            o_empty;
    logic            i_pop       = 1'b0;
    logic [1:0]      o_prim_kind;
    logic [ID_W-1:0] o_first_id;
    logic [ID_W-1:0] o_second_id;
    logic [ID_W-1:0] o_third_id;

    // Assembler state as the predictor sees it.
    logic            batch_open = 1'b0;
    logic [2:0]      open_mode  = '0;
    logic [1:0]      asm_phase  = '0;
    logic [1:0]      next_slot  = '0;
    logic [ID_W-1:0] id_slots [3] = '{default: '0};

    t_prim pending_prims [$];
    int    mismatches  = 0;
    int    words_sent  = 0;
    bit    steady      = 1'b0;

    primitive_assembly_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_func      (i_func),
        .i_mode      (i_mode),
        .i_vertex_id (i_vertex_id),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_prim_kind (o_prim_kind),
        .o_first_id  (o_first_id),
        .o_second_id (o_second_id),
        .o_third_id  (o_third_id)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic queue_prim(input t_kind k, input logic [ID_W-1:0] a, b, c);
        t_prim p;
        p.kind      = k;
        p.first_id  = a;
        p.second_id = b;
        p.third_id  = c;
        pending_prims.push_back(p);
    endtask

    task automatic place_vertex(input logic [ID_W-1:0] v);
        logic [1:0] p;
        logic [1:0] prev;
        logic [1:0] prev2;
        p     = (next_slot == 2'd3) ? 2'd0 : next_slot;
        prev  = (p == 2'd0) ? 2'd2 : p - 2'd1;
        prev2 = (p == 2'd2) ? 2'd0 : p + 2'd1;
        case (open_mode)
            MODE_POINTS: begin
                id_slots[0] = v;
                queue_prim(KIND_POINT, v, '0, '0);
            end
            MODE_LINES: begin
                id_slots[p] = v;
                p++;
                if (p >= 2'd2) begin
                    queue_prim(KIND_LINE, id_slots[0], id_slots[1], '0);
                    p = 2'd0;
                end
                next_slot = p;
            end
            MODE_LOOP: begin
                id_slots[p] = v;
                p++;
                if (asm_phase == 2'd2) begin
                    if (p[0]) queue_prim(KIND_LINE, id_slots[1], id_slots[2], '0);
                    else      queue_prim(KIND_LINE, id_slots[2], id_slots[1], '0);
                end else if (asm_phase == 2'd1) begin
                    queue_prim(KIND_LINE, id_slots[0], id_slots[1], '0);
                    asm_phase = 2'd2;
                end else begin
                    asm_phase = 2'd1;
                end
                if (p >= 2'd3) p = 2'd1;
                next_slot = p;
            end
            MODE_STRIP: begin
                id_slots[p] = v;
                p++;
                if (asm_phase != 2'd0) begin
                    if (p[0]) queue_prim(KIND_LINE, id_slots[1], id_slots[0], '0);
                    else      queue_prim(KIND_LINE, id_slots[0], id_slots[1], '0);
                end else begin
                    asm_phase = 2'd1;
                end
                if (p >= 2'd2) p = 2'd0;
                next_slot = p;
            end
            MODE_TRIS: begin
                id_slots[p] = v;
                p++;
                if (p >= 2'd3) begin
                    queue_prim(KIND_TRI, id_slots[0], id_slots[1], id_slots[2]);
                    p = 2'd0;
                end
                next_slot = p;
            end
            MODE_FAN, MODE_TRI_STRIP: begin
                id_slots[p] = v;
                // alternate the vertex order to hold the winding
                if (asm_phase == 2'd3) begin
                    queue_prim(KIND_TRI, id_slots[prev], id_slots[prev2], v);
                    asm_phase = 2'd2;
                end else if (asm_phase == 2'd2) begin
                    queue_prim(KIND_TRI, id_slots[prev2], id_slots[prev], v);
                    asm_phase = 2'd3;
                end else begin
                    asm_phase = asm_phase + 2'd1;
                end
                p++;
                // a fan keeps its pivot in slot 0
                if (p >= 2'd3) p = (open_mode == MODE_FAN) ? 2'd1 : 2'd0;
                next_slot = p;
            end
            default: ;
        endcase
    endtask

    task automatic assemble_word(input logic [1:0] f, input logic [2:0] m,
                                 input logic [ID_W-1:0] v);
        case (f)
            FUNC_BEGIN: begin
                if (batch_open || m == MODE_INVALID) begin
                    queue_prim(KIND_ERR, '0, '0, '0);
                end else begin
                    batch_open = 1'b1;
                    open_mode  = m;
                    asm_phase  = 2'd0;
                    next_slot  = 2'd0;
                end
            end
            FUNC_VERTEX: if (batch_open) place_vertex(v);
            FUNC_END: begin
                if (!batch_open) begin
                    queue_prim(KIND_ERR, '0, '0, '0);
                end else begin
                    // close the loop from the last vertex back to the first
                    if (open_mode == MODE_LOOP && asm_phase == 2'd2)
                        queue_prim(KIND_LINE,
                                   id_slots[(2'd3 - next_slot) == 2'd3 ? 2'd0
                                            : 2'd3 - next_slot],
                                   id_slots[0], '0);
                    batch_open = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [1:0] f, input logic [2:0] m,
                             input logic [ID_W-1:0] v);
        if (!steady) begin
            while ($urandom_range(99) < 19) begin
                i_push      <= 1'b0;
                i_func      <= 2'($urandom_range(3));
                i_mode      <= 3'($urandom_range(7));
                i_vertex_id <= 16'($urandom_range(65535));
                @(posedge i_clk);
            end
        end
        i_push      <= 1'b1;
        i_func      <= f;
        i_mode      <= m;
        i_vertex_id <= v;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        if (!(f == FUNC_UNUSED || (f == FUNC_VERTEX && !batch_open))) words_sent++;
        assemble_word(f, m, v);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return 16'($urandom_range(65535));
    endfunction

    task automatic check_field(input string what, input logic [ID_W-1:0] want, got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_prim want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_prims.size() == 0) begin
                $display("%0t ns: result expected none, got kind %0d ids %h %h %h",
                         $time, o_prim_kind, o_first_id, o_second_id, o_third_id);
                mismatches++;
            end else begin
                want = pending_prims.pop_front();
                check_field("prim_kind", 16'(want.kind), 16'(o_prim_kind));
                check_field("first_id", want.first_id, o_first_id);
                check_field("second_id", want.second_id, o_second_id);
                check_field("third_id", want.third_id, o_third_id);
            end
        end
        i_pop <= steady || ($urandom_range(99) >= 19);
    end

    task automatic test_protocol_errors();
        send_word(FUNC_END, MODE_POINTS, 16'h0000);
        send_word(FUNC_VERTEX, MODE_INVALID, 16'hFFFF);
        send_word(FUNC_UNUSED, MODE_INVALID, 16'hFFFF);
        send_word(FUNC_BEGIN, MODE_INVALID, 16'h0000);
        send_word(FUNC_BEGIN, MODE_TRIS, 16'h0000);
        send_word(FUNC_BEGIN, MODE_POINTS, 16'hFFFF);
        send_word(FUNC_VERTEX, MODE_POINTS, 16'h0000);
        send_word(FUNC_VERTEX, MODE_INVALID, 16'hFFFF);
        send_word(FUNC_VERTEX, MODE_POINTS, 16'hA5A5);
        send_word(FUNC_END, MODE_INVALID, 16'h0000);
    endtask

    task automatic test_loop_close();
        for (int n = 0; n <= 3; n++) begin
            send_word(FUNC_BEGIN, MODE_LOOP, '0);
            for (int k = 0; k < n; k++)
                send_word(FUNC_VERTEX, MODE_LOOP, 16'(16'h1111 * (k + 1)));
            send_word(FUNC_END, MODE_LOOP, '0);
        end
    endtask

    task automatic test_random_batches();
        int n;
        while (words_sent < RANDOM_WORDS + 24) begin
            steady = (words_sent >= 700 && words_sent < 1000);
            if ($urandom_range(99) < 85) begin
                send_word(FUNC_BEGIN, 3'($urandom_range(6)), pick_id());
                n = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(9);
                repeat (n) begin
                    // drop in a stray word now and then
                    if ($urandom_range(99) < 4)
                        send_word(2'($urandom_range(3)), 3'($urandom_range(7)), pick_id());
                    send_word(FUNC_VERTEX, 3'($urandom_range(7)), pick_id());
                end
                send_word(FUNC_END, 3'($urandom_range(7)), pick_id());
            end else begin
                send_word(2'($urandom_range(3)), 3'($urandom_range(7)), pick_id());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_protocol_errors();
        test_loop_close();
        test_random_batches();
        i_push <= 1'b0;
        while (pending_prims.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("primitive_assembly_top_tb: clean");
        else
            $display("primitive_assembly_top_tb: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("primitive_assembly_top_tb: errors");
        $finish;
    end

endmodule
